@@ src/ostt_pkg.sv @@
// ----------------------------------------------------------------------------
// ostt_pkg: shared types and constants of the timer table
// Beat payloads, command and result codes, and the cell update opcodes.
// ----------------------------------------------------------------------------
package ostt_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int TIME_BITS_DEF = 48;
	localparam int SLOT_W        = 4;
	localparam int DELAY_W       = 32;
	localparam int TIME_OUT_W    = 48;

	typedef enum logic [1:0] {
		CMD_TICK         = 2'd0,
		CMD_ARM_ONCE     = 2'd1,
		CMD_ARM_PERIODIC = 2'd2,
		CMD_CANCEL       = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_ARMED  = 3'd0,
		KIND_FULL   = 3'd1,
		KIND_CANCEL = 3'd2,
		KIND_FIRED  = 3'd3,
		KIND_TICK   = 3'd4
	} kind_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [SLOT_W-1:0]   timer_slot;
		logic [DELAY_W-1:0]  delay;
	} req_t;

	typedef struct packed {
		kind_t                 kind;
		logic [SLOT_W-1:0]     slot;
		logic [TIME_OUT_W-1:0] time_now;
		logic                  last;
	} rsp_t;

	typedef enum logic [1:0] {
		UPD_NONE    = 2'd0,
		UPD_ARM     = 2'd1,
		UPD_CLEAR   = 2'd2,
		UPD_RESCHED = 2'd3
	} upd_op_t;

	// Flags that travel down the chain next to the candidate data.
	typedef struct packed {
		logic act_found;
		logic free_found;
	} scan_flags_t;

endpackage

@@ src/ostt_cell.sv @@
// ----------------------------------------------------------------------------
// ostt_cell: one timer slot of the chain
// Holds the slot state and merges it into the candidate passed from the
// previous cell: earliest active deadline and lowest free slot.
// ----------------------------------------------------------------------------
module ostt_cell
	import ostt_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF,
	parameter int CELL_IDX  = 0,
	localparam int IDX_W    = $clog2(NUM_SLOTS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  upd_op_t              upd_op,
	input  logic [IDX_W-1:0]     upd_idx,
	input  logic [TIME_BITS-1:0] upd_dl,
	input  logic [DELAY_W-1:0]   upd_per,
	input  scan_flags_t          prev_flags,
	input  logic [TIME_BITS-1:0] prev_dl,
	input  logic [DELAY_W-1:0]   prev_per,
	input  logic [IDX_W-1:0]     prev_idx,
	input  logic [IDX_W-1:0]     prev_free_idx,
	output scan_flags_t          next_flags,
	output logic [TIME_BITS-1:0] next_dl,
	output logic [DELAY_W-1:0]   next_per,
	output logic [IDX_W-1:0]     next_idx,
	output logic [IDX_W-1:0]     next_free_idx
);

	logic                 active_q;
	logic [TIME_BITS-1:0] dl_q;
	logic [DELAY_W-1:0]   per_q;
	scan_flags_t          flags_q;
	logic [TIME_BITS-1:0] cand_dl_q;
	logic [DELAY_W-1:0]   cand_per_q;
	logic [IDX_W-1:0]     cand_idx_q;
	logic [IDX_W-1:0]     free_idx_q;

	logic [IDX_W-1:0] my_idx;
	logic             hit;
	logic             take_act;
	logic             take_free;

	assign my_idx = IDX_W'(CELL_IDX);
	assign hit    = (upd_idx == my_idx);

	// Strictly earlier only, so a tie keeps the lower slot from upstream.
	assign take_act  = active_q && (!prev_flags.act_found || (dl_q < prev_dl));
	assign take_free = !active_q && !prev_flags.free_found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			flags_q  <= '0;
		end else begin
			flags_q.act_found  <= prev_flags.act_found || active_q;
			flags_q.free_found <= prev_flags.free_found || !active_q;
			if (hit) begin
				case (upd_op)
					UPD_ARM:   active_q <= 1'b1;
					UPD_CLEAR: active_q <= 1'b0;
					default:   ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit && (upd_op == UPD_ARM)) begin
			dl_q  <= upd_dl;
			per_q <= upd_per;
		end else if (hit && (upd_op == UPD_RESCHED)) begin
			dl_q <= upd_dl;
		end
		if (take_act) begin
			cand_dl_q  <= dl_q;
			cand_per_q <= per_q;
			cand_idx_q <= my_idx;
		end else begin
			cand_dl_q  <= prev_dl;
			cand_per_q <= prev_per;
			cand_idx_q <= prev_idx;
		end
		free_idx_q <= take_free ? my_idx : prev_free_idx;
	end

	assign next_flags    = flags_q;
	assign next_dl       = cand_dl_q;
	assign next_per      = cand_per_q;
	assign next_idx      = cand_idx_q;
	assign next_free_idx = free_idx_q;

endmodule

@@ src/ostt_ctrl.sv @@
// ----------------------------------------------------------------------------
// ostt_ctrl: command sequencer of the timer table
// Takes a command beat, waits for the scan to settle at the chain tail, then
// updates at most one cell and hands out each result beat through an output register.
// ----------------------------------------------------------------------------
module ostt_ctrl
	import ostt_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF,
	localparam int IDX_W    = $clog2(NUM_SLOTS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  scan_flags_t          tail_flags,
	input  logic [TIME_BITS-1:0] tail_dl,
	input  logic [DELAY_W-1:0]   tail_per,
	input  logic [IDX_W-1:0]     tail_idx,
	input  logic [IDX_W-1:0]     tail_free_idx,
	output upd_op_t              upd_op,
	output logic [IDX_W-1:0]     upd_idx,
	output logic [TIME_BITS-1:0] upd_dl,
	output logic [DELAY_W-1:0]   upd_per
);

	localparam int CNT_W  = $clog2(NUM_SLOTS);
	localparam int FIRE_W = $clog2(NUM_SLOTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESOLVE
	} state_t;

	state_t               state_q;
	req_t                 req_q;
	logic [TIME_BITS-1:0] now_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [FIRE_W-1:0]    fires_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic                 out_free;
	logic                 fire_ok;
	logic                 in_range;
	logic [DELAY_W-1:0]   addend;
	logic [TIME_BITS-1:0] sum;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign fire_ok  = tail_flags.act_found && (tail_dl <= now_q)
		&& (fires_q != FIRE_W'(NUM_SLOTS));
	assign in_range = (32'(req_q.timer_slot) < 32'(NUM_SLOTS));
	assign addend   = (req_q.cmd == CMD_TICK) ? tail_per : req_q.delay;
	assign sum      = now_q + TIME_BITS'(addend);

	always_comb begin
		upd_op  = UPD_NONE;
		upd_idx = tail_idx;
		upd_dl  = sum;
		upd_per = req_q.delay;
		if ((state_q == ST_RESOLVE) && out_free) begin
			case (req_q.cmd)
				CMD_TICK: begin
					if (fire_ok) begin
						upd_op = (tail_per != '0) ? UPD_RESCHED : UPD_CLEAR;
					end
				end
				CMD_ARM_ONCE, CMD_ARM_PERIODIC: begin
					if (tail_flags.free_found) begin
						upd_op  = UPD_ARM;
						upd_idx = tail_free_idx;
						upd_per = (req_q.cmd == CMD_ARM_PERIODIC) ? req_q.delay : '0;
					end
				end
				CMD_CANCEL: begin
					if (in_range) begin
						upd_op  = UPD_CLEAR;
						upd_idx = IDX_W'(req_q.timer_slot);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			now_q       <= '0;
			cnt_q       <= '0;
			fires_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// In the resolve state a taken beat is replaced by the next one below.
			if ((state_q != ST_RESOLVE) && rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						cnt_q   <= CNT_W'(NUM_SLOTS - 1);
						fires_q <= '0;
						if (req.cmd == CMD_TICK) begin
							now_q <= now_q + TIME_BITS'(1);
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// The tail is settled once every cell has passed on stable state.
					if (cnt_q == '0) begin
						state_q <= ST_RESOLVE;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_RESOLVE: begin
					if (out_free) begin
						rsp_valid_q    <= 1'b1;
						rsp_q.time_now <= TIME_OUT_W'(now_q);
						case (req_q.cmd)
							CMD_TICK: begin
								if (fire_ok) begin
									rsp_q.kind <= KIND_FIRED;
									rsp_q.slot <= SLOT_W'(tail_idx);
									rsp_q.last <= 1'b0;
									fires_q    <= fires_q + FIRE_W'(1);
									cnt_q      <= CNT_W'(NUM_SLOTS - 1);
									state_q    <= ST_SCAN;
								end else begin
									rsp_q.kind <= KIND_TICK;
									rsp_q.slot <= '0;
									rsp_q.last <= 1'b1;
									state_q    <= ST_IDLE;
								end
							end
							CMD_ARM_ONCE, CMD_ARM_PERIODIC: begin
								rsp_q.last <= 1'b1;
								state_q    <= ST_IDLE;
								if (tail_flags.free_found) begin
									rsp_q.kind <= KIND_ARMED;
									rsp_q.slot <= SLOT_W'(tail_free_idx);
								end else begin
									rsp_q.kind <= KIND_FULL;
									rsp_q.slot <= '0;
								end
							end
							CMD_CANCEL: begin
								rsp_q.kind <= KIND_CANCEL;
								rsp_q.slot <= req_q.timer_slot;
								rsp_q.last <= 1'b1;
								state_q    <= ST_IDLE;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ src/one_shot_periodic_timer_table.sv @@
// ----------------------------------------------------------------------------
// one_shot_periodic_timer_table: tick-driven table of timer slots
//
//   channel | dir | payload | beat taken when
//   --------+-----+---------+------------------------------
//   req     | in  | req_t   | req_valid high, req_stall low
//   rsp     | out | rsp_t   | rsp_valid high, rsp_stall low
//
// One command at a time. Each result waits for the scan to settle along the
// cell chain, one register per slot; a tick rescans the chain after every
// fired timer. Reset empties the table and zeroes the time at once. A
// stalled result holds the sequencer but the next command is accepted
// while the last result of the previous one still waits.
// ----------------------------------------------------------------------------
module one_shot_periodic_timer_table
	import ostt_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IDX_W = $clog2(NUM_SLOTS);

	scan_flags_t          link_flags    [NUM_SLOTS+1];
	logic [TIME_BITS-1:0] link_dl       [NUM_SLOTS+1];
	logic [DELAY_W-1:0]   link_per      [NUM_SLOTS+1];
	logic [IDX_W-1:0]     link_idx      [NUM_SLOTS+1];
	logic [IDX_W-1:0]     link_free_idx [NUM_SLOTS+1];

	upd_op_t              upd_op;
	logic [IDX_W-1:0]     upd_idx;
	logic [TIME_BITS-1:0] upd_dl;
	logic [DELAY_W-1:0]   upd_per;

	assign link_flags[0]    = '0;
	assign link_dl[0]       = '0;
	assign link_per[0]      = '0;
	assign link_idx[0]      = '0;
	assign link_free_idx[0] = '0;

	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
		ostt_cell #(
			.NUM_SLOTS (NUM_SLOTS),
			.TIME_BITS (TIME_BITS),
			.CELL_IDX  (g)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.upd_op        (upd_op),
			.upd_idx       (upd_idx),
			.upd_dl        (upd_dl),
			.upd_per       (upd_per),
			.prev_flags    (link_flags[g]),
			.prev_dl       (link_dl[g]),
			.prev_per      (link_per[g]),
			.prev_idx      (link_idx[g]),
			.prev_free_idx (link_free_idx[g]),
			.next_flags    (link_flags[g+1]),
			.next_dl       (link_dl[g+1]),
			.next_per      (link_per[g+1]),
			.next_idx      (link_idx[g+1]),
			.next_free_idx (link_free_idx[g+1])
		);
	end

	ostt_ctrl #(
		.NUM_SLOTS (NUM_SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.tail_flags    (link_flags[NUM_SLOTS]),
		.tail_dl       (link_dl[NUM_SLOTS]),
		.tail_per      (link_per[NUM_SLOTS]),
		.tail_idx      (link_idx[NUM_SLOTS]),
		.tail_free_idx (link_free_idx[NUM_SLOTS]),
		.upd_op        (upd_op),
		.upd_idx       (upd_idx),
		.upd_dl        (upd_dl),
		.upd_per       (upd_per)
	);

endmodule

@@ src/ostt_checker.sv @@
// ----------------------------------------------------------------------------
// ostt_checker: port-level checks of the timer table
// Watches both channels and the result sequence of each command.
// ----------------------------------------------------------------------------
module ostt_checker
	import ostt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// A stalled result beat stays and holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result beat dropped or changed under stall");

	// Commands are taken one at a time.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second command taken before the first finished");

	// Only a fired beat leaves more results of the same command to come.
	a_last_fired: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.kind == KIND_FIRED) == !rsp.last))
		else $error("last flag does not match result kind");

	// Table full and tick done carry no slot.
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((rsp.kind == KIND_FULL) || (rsp.kind == KIND_TICK))
		|-> (rsp.slot == '0))
		else $error("slot not zero on a slotless result");

endmodule

bind one_shot_periodic_timer_table ostt_checker u_ostt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
